>>> design/pir_pkg.sv
// ----------------------------------------------------------------------------
// pir_pkg
// Shared types and constants for the palette index remapper.
// ----------------------------------------------------------------------------
package pir_pkg;

    // Fixed field widths of the two channels.
    localparam int GIDX_W  = 8;
    localparam int LOCAL_W = 6;

    // Defaults for the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int INDEX_BITS_DEF  = 8;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;

    // One queued influence item, with its value already masked.
    typedef struct packed {
        logic              start_group;
        logic              has_influence;
        logic [GIDX_W-1:0] value;
    } item_t;

endpackage

>>> design/pir_front.sv
// ----------------------------------------------------------------------------
// pir_front
// Input side: masks the incoming index and queues the item for the back part.
// ----------------------------------------------------------------------------
module pir_front #(
    parameter int INDEX_BITS = pir_pkg::INDEX_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_start_group,
    input  logic                        s_has_influence,
    input  logic [pir_pkg::GIDX_W-1:0]  s_global_index,
    output logic                        q_valid,
    output pir_pkg::item_t              q_item,
    input  logic                        q_pop
);

    localparam int PTR_W = (pir_pkg::QUEUE_DEPTH > 1) ? $clog2(pir_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pir_pkg::QUEUE_DEPTH + 1);
    localparam logic [pir_pkg::GIDX_W-1:0] VAL_MASK =
        (INDEX_BITS >= pir_pkg::GIDX_W) ? {pir_pkg::GIDX_W{1'b1}}
                                        : pir_pkg::GIDX_W'((1 << INDEX_BITS) - 1);

    pir_pkg::item_t    q_mem_reg [pir_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    pir_pkg::item_t    in_item;
    logic              push;

    // Only the low INDEX_BITS bits of the index take part in matching.
    always_comb begin
        in_item.start_group   = s_start_group;
        in_item.has_influence = s_has_influence;
        in_item.value         = s_global_index & VAL_MASK;
    end

    assign s_ready = (cnt_reg != CNT_W'(pir_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(pir_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(pir_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> design/pir_back.sv
// ----------------------------------------------------------------------------
// pir_back
// Group table with one comparator per entry, a two-step sequencer and the
// result register.
// ----------------------------------------------------------------------------
module pir_back #(
    parameter int TABLE_DEPTH = pir_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = pir_pkg::INDEX_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  pir_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pir_pkg::LOCAL_W-1:0] m_local_index,
    output logic                        m_newly_added,
    output logic                        m_skipped,
    output logic                        m_overflow
);

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = (INDEX_BITS < pir_pkg::GIDX_W) ? INDEX_BITS : pir_pkg::GIDX_W;
    localparam int LW = pir_pkg::LOCAL_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RES  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [EW-1:0]        entry_reg [TABLE_DEPTH];
    logic [CW-1:0]        count_reg, count_next;
    pir_pkg::item_t       item_reg;
    logic [TABLE_DEPTH-1:0] match_reg, match_next;
    logic                 m_valid_reg, m_valid_next;
    logic [LW-1:0]        local_reg;
    logic                 added_reg, skipped_reg, ovf_reg;

    logic [CW-1:0]        cmp_count;
    logic [CW-1:0]        res_count;
    logic [PW-1:0]        hit_pos;
    logic                 hit, full, append, fire;
    logic [PW+LW-1:0]     pos_ext;
    logic [CW+LW-1:0]     cnt_ext;
    logic [LW-1:0]        res_local;

    // Compare step: each valid entry checks the incoming value on its own.
    always_comb begin
        cmp_count = q_item.start_group ? '0 : count_reg;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match_next[i] = (CW'(i) < cmp_count) &&
                            (entry_reg[i] == q_item.value[EW-1:0]);
        end
    end

    // Resolve step: entries are distinct, so the match vector is one-hot or empty.
    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_pos = hit_pos | (match_reg[i] ? PW'(i) : '0);
        end
        hit       = |match_reg;
        res_count = item_reg.start_group ? '0 : count_reg;
        full      = (res_count == CW'(TABLE_DEPTH));
        append    = item_reg.has_influence && !hit && !full;
        pos_ext   = {{LW{1'b0}}, hit_pos};
        cnt_ext   = {{LW{1'b0}}, res_count};
        if (!item_reg.has_influence) begin
            res_local = '0;
        end else if (hit) begin
            res_local = pos_ext[LW-1:0];
        end else if (append) begin
            res_local = cnt_ext[LW-1:0];
        end else begin
            res_local = '0;
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign fire  = (state_reg == ST_RES) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if (fire) begin
                    state_next   = ST_IDLE;
                    count_next   = append ? res_count + 1'b1 : res_count;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg  <= q_item;
            match_reg <= match_next;
        end
        if (fire) begin
            local_reg   <= res_local;
            added_reg   <= append;
            skipped_reg <= !item_reg.has_influence;
            ovf_reg     <= item_reg.has_influence && !hit && full;
        end
        if (fire && append) begin
            entry_reg[res_count[PW-1:0]] <= item_reg.value[EW-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_local_index = local_reg;
    assign m_newly_added = added_reg;
    assign m_skipped     = skipped_reg;
    assign m_overflow    = ovf_reg;

endmodule

>>> design/palette_index_remapper_top.sv
// ----------------------------------------------------------------------------
// palette_index_remapper_top
// Remaps global bone indices onto compact per-group local indices.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_valid/s_ready    start_group, has_influence, global_index
//  m_*       out        m_valid/m_ready    local_index, newly_added, skipped, overflow
//
// Each transaction passes through the back part in a compare step, in which
// every table entry compares itself against the value, and then a resolve
// step, in which the match is encoded and the table and entry count are
// updated. The next transaction cannot start its compare before that update,
// so the back part takes no new transaction until it is through with the last.
// Reset (aresetn, synchronous, active low) empties the queue, the table count
// and the result register; table entries themselves are not cleared.
// A two-entry queue keeps accepting while a result waits on m_ready.
//
// The front part masks the index to its matching width and queues the
// transaction. The back part holds the group table as one register and one
// comparator per entry. A start-of-group flag resets the entry count before
// the compare, so old entries simply stop taking part. A value not found is
// appended at the current count; when the table is already full the result
// reports overflow with local index zero and the table is left alone.
// Positions beyond the local index width wrap modulo 64.
// ----------------------------------------------------------------------------
module palette_index_remapper_top #(
    parameter int TABLE_DEPTH = pir_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = pir_pkg::INDEX_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_start_group,
    input  logic                        s_has_influence,
    input  logic [pir_pkg::GIDX_W-1:0]  s_global_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pir_pkg::LOCAL_W-1:0] m_local_index,
    output logic                        m_newly_added,
    output logic                        m_skipped,
    output logic                        m_overflow
);

    logic           q_valid;
    logic           q_pop;
    pir_pkg::item_t q_item;

    // Front part: masking and the transaction queue.
    pir_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_group   (s_start_group),
        .s_has_influence (s_has_influence),
        .s_global_index  (s_global_index),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    // Back part: group table, lookup sequencer and result register.
    pir_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_BITS  (INDEX_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_local_index (m_local_index),
        .m_newly_added (m_newly_added),
        .m_skipped     (m_skipped),
        .m_overflow    (m_overflow)
    );

endmodule

>>> design/pir_checker.sv
// ----------------------------------------------------------------------------
// pir_checker
// Port-level checks for the palette index remapper, bound to the top level.
// ----------------------------------------------------------------------------
module pir_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pir_pkg::LOCAL_W-1:0] m_local_index,
    input logic                        m_newly_added,
    input logic                        m_skipped,
    input logic                        m_overflow
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_local_index) &&
        $stable(m_newly_added) && $stable(m_skipped) && $stable(m_overflow))
        else $error("result changed while stalled");

    // At most one outcome flag per result.
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_newly_added, m_skipped, m_overflow}))
        else $error("conflicting outcome flags");

    // Skipped and overflow results carry local index zero.
    a_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_skipped || m_overflow) |-> m_local_index == '0)
        else $error("nonzero index on skipped or overflow result");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind palette_index_remapper_top pir_checker u_pir_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_local_index (m_local_index),
    .m_newly_added (m_newly_added),
    .m_skipped     (m_skipped),
    .m_overflow    (m_overflow)
);
